>>> src/grps_pkg.sv
// shared types and constants for the glyph row padding scanner
package grps_pkg;

   localparam int CountWidth = 11;
   localparam int PadWidth   = 8;

   localparam logic [31:0] EmptyTestMask = 32'h000F_0F0F;
   localparam logic [PadWidth-1:0] PadSat      = 8'd254;
   localparam logic [PadWidth-1:0] PadAllEmpty = 8'd255;

   localparam logic [CountWidth-1:0] CellWidthReset = 11'd8;

   typedef enum logic [7:0] {
      REG_INVERT_COLOR = 8'd0,
      REG_CELL_WIDTH   = 8'd1
   } reg_index_type;

   typedef struct packed {
      logic [31:0]          pixel_out;
      logic                 transparent;
      logic                 row_done;
      logic [PadWidth-1:0]  left_pad;
      logic [PadWidth-1:0]  right_pad;
   } result_type;

endpackage

>>> src/grps_out_stage.sv
// result register with skid entry for the glyph row padding scanner
module grps_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_stall,
   input  grps_pkg::result_type in_data,
   output logic                out_valid,
   input  logic                out_stall,
   output grps_pkg::result_type out_data
);

   logic                 main_valid_ff;
   logic                 skid_valid_ff;
   grps_pkg::result_type main_data_ff;
   grps_pkg::result_type skid_data_ff;
   logic                 in_fire;
   logic                 out_fire;

   assign in_stall  = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;
   assign in_fire   = in_valid & ~skid_valid_ff;
   assign out_fire  = main_valid_ff & ~out_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (in_fire) begin
            if (!main_valid_ff || out_fire) begin
               main_valid_ff <= 1'b1;
               main_data_ff  <= in_data;
            end else begin
               skid_valid_ff <= 1'b1;
               skid_data_ff  <= in_data;
            end
         end else if (out_fire) begin
            if (skid_valid_ff) begin
               main_data_ff  <= skid_data_ff;
               skid_valid_ff <= 1'b0;
            end else begin
               main_valid_ff <= 1'b0;
            end
         end
      end
   end

endmodule

>>> src/glyph_row_padding_scanner.sv
// top level of the glyph row padding scanner
// One pixel per cycle: a pixel transaction is taken on any cycle the result
// side keeps up, and its result is held in the result register or the skid
// entry. A two-entry output stage (result register plus skid entry) holds
// results while rsp_stall is high; req_stall rises only when both entries
// are full. Each pixel is optionally inverted, flagged transparent when the
// low nibbles of its three colour bytes are zero, and the last pixel of each
// cell row carries the leading and trailing empty counts (saturated at 254,
// 255 for both on an all-empty row). Registers: index 0 invert_color,
// index 1 cell_width (0 acts as 1, values above MAX_CELL_WIDTH are clamped);
// other indexes are ignored. csr_ready is always high.
module glyph_row_padding_scanner #(
   parameter int MAX_CELL_WIDTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_pixel_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_pixel_out,
   output logic        rsp_transparent,
   output logic        rsp_row_done,
   output logic [7:0]  rsp_left_pad,
   output logic [7:0]  rsp_right_pad,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [10:0] csr_wdata
);

   localparam int CW = grps_pkg::CountWidth;
   localparam logic [CW-1:0] MaxWidth = CW'(MAX_CELL_WIDTH);

   logic                 invert_color_ff;
   logic [CW-1:0]        cell_width_ff;
   logic [CW-1:0]        column_count_ff;
   logic [CW-1:0]        leading_empty_ff;
   logic [CW-1:0]        trailing_empty_ff;
   logic                 ink_seen_ff;

   logic [CW-1:0]        column_count_in;
   logic [CW-1:0]        leading_empty_in;
   logic [CW-1:0]        trailing_empty_in;
   logic                 ink_seen_in;

   logic                 in_fire;
   logic [31:0]          pixel;
   logic                 empty;
   logic [CW-1:0]        eff_width;
   logic [CW:0]          taken;
   logic                 done;
   logic [CW-1:0]        le_upd;
   logic [CW-1:0]        te_upd;
   logic                 ink_upd;
   grps_pkg::result_type result;

   assign csr_ready = 1'b1;
   assign in_fire   = req_valid & ~req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         invert_color_ff <= 1'b0;
         cell_width_ff   <= grps_pkg::CellWidthReset;
      end else if (csr_valid && csr_ready) begin
         case (grps_pkg::reg_index_type'(csr_index))
            grps_pkg::REG_INVERT_COLOR: invert_color_ff <= csr_wdata[0];
            grps_pkg::REG_CELL_WIDTH:   cell_width_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      pixel   = invert_color_ff ? ~req_pixel_in : req_pixel_in;
      empty   = (pixel & grps_pkg::EmptyTestMask) == 32'd0;

      if (cell_width_ff == '0) begin
         eff_width = CW'(1);
      end else if (cell_width_ff > MaxWidth) begin
         eff_width = MaxWidth;
      end else begin
         eff_width = cell_width_ff;
      end

      le_upd  = (empty && !ink_seen_ff) ? leading_empty_ff + CW'(1) : leading_empty_ff;
      if (!empty) begin
         te_upd = '0;
      end else if (ink_seen_ff) begin
         te_upd = trailing_empty_ff + CW'(1);
      end else begin
         te_upd = trailing_empty_ff;
      end
      ink_upd = ink_seen_ff | ~empty;

      taken   = {1'b0, column_count_ff} + (CW+1)'(1);
      done    = taken >= {1'b0, eff_width};

      result.pixel_out   = pixel;
      result.transparent = empty;
      result.row_done    = done;
      result.left_pad    = '0;
      result.right_pad   = '0;
      if (done) begin
         if (!ink_upd) begin
            result.left_pad  = grps_pkg::PadAllEmpty;
            result.right_pad = grps_pkg::PadAllEmpty;
         end else begin
            result.left_pad  = (le_upd > CW'(grps_pkg::PadSat)) ?
                               grps_pkg::PadSat : le_upd[grps_pkg::PadWidth-1:0];
            result.right_pad = (te_upd > CW'(grps_pkg::PadSat)) ?
                               grps_pkg::PadSat : te_upd[grps_pkg::PadWidth-1:0];
         end
      end

      if (done) begin
         column_count_in   = '0;
         leading_empty_in  = '0;
         trailing_empty_in = '0;
         ink_seen_in       = 1'b0;
      end else begin
         column_count_in   = taken[CW-1:0];
         leading_empty_in  = le_upd;
         trailing_empty_in = te_upd;
         ink_seen_in       = ink_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff   <= '0;
         leading_empty_ff  <= '0;
         trailing_empty_ff <= '0;
         ink_seen_ff       <= 1'b0;
      end else if (in_fire) begin
         column_count_ff   <= column_count_in;
         leading_empty_ff  <= leading_empty_in;
         trailing_empty_ff <= trailing_empty_in;
         ink_seen_ff       <= ink_seen_in;
      end
   end

   grps_pkg::result_type rsp_data;

   grps_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_data   (result),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

   assign rsp_pixel_out   = rsp_data.pixel_out;
   assign rsp_transparent = rsp_data.transparent;
   assign rsp_row_done    = rsp_data.row_done;
   assign rsp_left_pad    = rsp_data.left_pad;
   assign rsp_right_pad   = rsp_data.right_pad;

endmodule

>>> tb/sv/tb_top.sv
// self-checking testbench for the glyph row padding scanner: pixel stream, row pads, registers
`timescale 1ns / 100ps

module tb_top;

   localparam int MaxCellWidth = 1024;
   localparam logic [7:0] RegIndexFirstUnused = 8'd2;
   localparam logic [7:0] RegIndexAllOnes = 8'hFF;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_pixel_in;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_pixel_out;
   logic        rsp_transparent;
   logic        rsp_row_done;
   logic [7:0]  rsp_left_pad;
   logic [7:0]  rsp_right_pad;
   logic        csr_valid;
   logic        csr_ready;
   logic [7:0]  csr_index;
   logic [10:0] csr_wdata;

   // scanner state and register copies
   logic                            invert_on = 1'b0;
   logic [grps_pkg::CountWidth-1:0] width_reg = grps_pkg::CellWidthReset;
   logic [grps_pkg::CountWidth-1:0] col_cnt = '0;
   logic [grps_pkg::CountWidth-1:0] lead_cnt = '0;
   logic [grps_pkg::CountWidth-1:0] trail_cnt = '0;
   logic                            ink_seen = 1'b0;

   grps_pkg::result_type pending_results[$];
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int pixels_sent = 0;
   int mismatch_count = 0;

   glyph_row_padding_scanner #(
      .MAX_CELL_WIDTH(MaxCellWidth)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_pixel_in(req_pixel_in),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_pixel_out(rsp_pixel_out),
      .rsp_transparent(rsp_transparent),
      .rsp_row_done(rsp_row_done),
      .rsp_left_pad(rsp_left_pad),
      .rsp_right_pad(rsp_right_pad),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   function automatic int row_length();
      if (width_reg == '0)
         return 1;
      if (width_reg > MaxCellWidth)
         return MaxCellWidth;
      return int'(width_reg);
   endfunction

   function automatic grps_pkg::result_type scan_pixel(input logic [31:0] px);
      grps_pkg::result_type r;
      logic [31:0] v;
      logic blank;
      v = invert_on ? ~px : px;
      blank = (v & grps_pkg::EmptyTestMask) == 32'h0;
      if (blank) begin
         if (ink_seen)
            trail_cnt = trail_cnt + 1'b1;
         else
            lead_cnt = lead_cnt + 1'b1;
      end else begin
         ink_seen = 1'b1;
         trail_cnt = '0;
      end
      r.pixel_out = v;
      r.transparent = blank;
      r.row_done = (int'(col_cnt) + 1) >= row_length();
      r.left_pad = '0;
      r.right_pad = '0;
      if (r.row_done) begin
         if (!ink_seen) begin
            r.left_pad = grps_pkg::PadAllEmpty;
            r.right_pad = grps_pkg::PadAllEmpty;
         end else begin
            r.left_pad = (lead_cnt > grps_pkg::PadSat) ?
                         grps_pkg::PadSat : lead_cnt[grps_pkg::PadWidth-1:0];
            r.right_pad = (trail_cnt > grps_pkg::PadSat) ?
                          grps_pkg::PadSat : trail_cnt[grps_pkg::PadWidth-1:0];
         end
         col_cnt = '0;
         lead_cnt = '0;
         trail_cnt = '0;
         ink_seen = 1'b0;
      end else begin
         col_cnt = col_cnt + 1'b1;
      end
      return r;
   endfunction

   // raw word whose post-inversion value is empty or inked as asked
   function automatic logic [31:0] make_pixel(input int pct_empty, input int pct_noise);
      logic [31:0] v;
      v = $urandom;
      if ($urandom_range(0, 99) < pct_noise)
         return v;
      if ($urandom_range(0, 99) < pct_empty)
         v = v & ~grps_pkg::EmptyTestMask;
      else
         v = v | (32'h1 << ($urandom_range(0, 3) + 8 * $urandom_range(0, 2)));
      return invert_on ? ~v : v;
   endfunction

   function automatic logic [10:0] pick_width();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0)
         return 11'd0;
      if (r == 1)
         return 11'($urandom_range(17, 40));
      return 11'($urandom_range(1, 16));
   endfunction

   task automatic report_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
      if (want !== got) begin
         mismatch_count++;
         $display("%0t %s expected %0h actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : check_results
      grps_pkg::result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            $display("%0t unexpected result: expected none actual pixel %0h", $time,
                     rsp_pixel_out);
         end else begin
            want = pending_results.pop_front();
            report_field("pixel_out", want.pixel_out, rsp_pixel_out);
            report_field("transparent", 32'(want.transparent), 32'(rsp_transparent));
            report_field("row_done", 32'(want.row_done), 32'(rsp_row_done));
            report_field("left_pad", 32'(want.left_pad), 32'(rsp_left_pad));
            report_field("right_pad", 32'(want.right_pad), 32'(rsp_right_pad));
         end
      end
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   task automatic send_pixel(input logic [31:0] px);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel_in <= px;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(scan_pixel(px));
      pixels_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_reg(input logic [7:0] idx, input logic [10:0] val);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == grps_pkg::REG_INVERT_COLOR)
         invert_on = val[0];
      else if (idx == grps_pkg::REG_CELL_WIDTH)
         width_reg = val;
   endtask

   task automatic send_run(input int count, input int pct_empty);
      for (int i = 0; i < count; i++)
         send_pixel(make_pixel(pct_empty, 0));
   endtask

   task automatic send_row(input int pct_empty, input int pct_noise);
      int left;
      left = row_length() - int'(col_cnt);
      if (left < 1)
         left = 1;
      for (int i = 0; i < left; i++)
         send_pixel(make_pixel(pct_empty, pct_noise));
   endtask

   task automatic test_reset_width_row();
      send_pixel(32'h0000_0000);
      send_pixel(32'hFFFF_FFFF);
      send_pixel(grps_pkg::EmptyTestMask);
      send_pixel(32'h00F0_F0F0);
      send_pixel(32'hFF00_0000);
      send_pixel(32'h0000_0100);
      send_pixel(32'h0000_0000);
      send_pixel(32'h0000_0000);
   endtask

   task automatic test_narrow_width_and_invert();
      write_reg(grps_pkg::REG_CELL_WIDTH, 11'd1);
      send_pixel(32'h0000_0000);
      send_pixel(32'h0000_0001);
      write_reg(grps_pkg::REG_CELL_WIDTH, 11'd0);
      send_pixel(32'hFFF0_F0F0);
      send_pixel(32'h0008_0000);
      write_reg(grps_pkg::REG_INVERT_COLOR, 11'h7FF);
      send_pixel(32'hFFFF_FFFF);
      send_pixel(32'h0000_0000);
      write_reg(RegIndexAllOnes, 11'h000);
      write_reg(RegIndexFirstUnused, 11'h7FF);
      send_pixel(32'h00F0_F0F0);
      write_reg(grps_pkg::REG_INVERT_COLOR, 11'h7FE);
      send_pixel(32'h0000_0000);
   endtask

   task automatic test_width_change_mid_row();
      write_reg(grps_pkg::REG_CELL_WIDTH, 11'd6);
      send_run(4, 50);
      write_reg(grps_pkg::REG_CELL_WIDTH, 11'd3);
      send_run(1, 50);
      send_run(2, 0);
      write_reg(grps_pkg::REG_CELL_WIDTH, 11'd6);
      send_run(4, 50);
   endtask

   task automatic test_pad_saturation();
      write_reg(grps_pkg::REG_CELL_WIDTH, 11'd256);
      send_run(255, 100);
      send_run(1, 0);
      send_run(1, 0);
      send_run(255, 100);
   endtask

   task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                      input int n_items);
      int start_count;
      int pct_empty;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      start_count = pixels_sent;
      while (pixels_sent - start_count < n_items) begin
         case ($urandom_range(0, 15))
            0, 1: begin
               write_reg(grps_pkg::REG_CELL_WIDTH, pick_width());
            end
            2: begin
               write_reg(grps_pkg::REG_INVERT_COLOR, 11'($urandom_range(0, 2047)));
            end
            3: begin
               write_reg(8'($urandom_range(RegIndexFirstUnused, RegIndexAllOnes)),
                         11'($urandom_range(0, 2047)));
            end
            4: begin
               send_run($urandom_range(1, 5), 50);
            end
            5: begin
               drain();
            end
            default: begin
               case ($urandom_range(0, 3))
                  0: pct_empty = 0;
                  1: pct_empty = 30;
                  2: pct_empty = 70;
                  default: pct_empty = 100;
               endcase
               send_row(pct_empty, 5);
            end
         endcase
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_pixel_in <= '0;
      rsp_stall <= 1'b0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 35;
      recv_idle_pct = 70;
      test_reset_width_row();
      test_narrow_width_and_invert();
      test_width_change_mid_row();
      test_pad_saturation();
      write_reg(grps_pkg::REG_CELL_WIDTH, 11'd8);
      test_random_traffic(35, 70, 100);
      test_random_traffic(70, 35, 100);
      test_random_traffic(0, 0, 100);
      drain();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
